>>> src/slh_pkg.sv
// slh_pkg: shared constants, types and table builders for the sRGB luminance histogram
// depends on nothing; imported by every module of the block
`default_nettype none

package slh_pkg;

   // sizes
   localparam int BIN_COUNT        = 256;
   localparam int BIN_W            = $clog2(BIN_COUNT);
   localparam int COUNT_BITS       = 32;
   localparam int LINEAR_FRAC_BITS = 16;
   localparam int LIN_W            = LINEAR_FRAC_BITS + 1;
   localparam int LIN8_ENTRIES     = 256;
   localparam int LIN16_ENTRIES    = 4097;
   localparam int LIN16_AW         = $clog2(LIN16_ENTRIES);
   localparam int ACC_W            = 33;
   localparam int WQ               = 30;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [LIN_W-1:0]      ONE_LIN   = LIN_W'(1) << LINEAR_FRAC_BITS;
   localparam logic [ACC_W-1:0]      LUM_ROUND = ACC_W'(32768);

   // rec.709 weights over 65536
   localparam logic [15:0] W_RED   = 16'd13933;
   localparam logic [15:0] W_GREEN = 16'd46871;
   localparam logic [15:0] W_BLUE  = 16'd4732;

   // denominators of the three decode tables
   localparam logic [63:0] DEN_8  = 64'd255;
   localparam logic [63:0] DEN_16 = 64'd65535;
   localparam logic [63:0] DEN_T  = 64'd256;
   localparam logic [63:0] DL_8   = 64'd255 * 64'd1292;
   localparam logic [63:0] DL_16  = 64'd65535 * 64'd1292;
   localparam logic [63:0] DL_T   = 64'd256 * 64'd1292;
   localparam logic [63:0] DX_8   = 64'd1055 * 64'd255;
   localparam logic [63:0] DX_16  = 64'd1055 * 64'd65535;
   localparam logic [63:0] DX_T   = 64'd1055 * 64'd256;

   typedef enum logic [1:0] {
      TBL_LIN8,
      TBL_LIN16,
      TBL_THRESH
   } tbl_kind_type;

   typedef enum logic [0:0] {
      OP_ADD  = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LO,
      ST_HI,
      ST_MIX,
      ST_ACC,
      ST_SEARCH,
      ST_FETCH,
      ST_UPDATE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic [1:0] ch;
      logic       rom_hi;
      logic       cap_lo;
      logic       cap_v;
      logic       acc_en;
      logic       search_en;
      logic [2:0] search_bit;
      logic       fetch;
      logic       update;
      logic       rsp_load;
   } slh_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op;
      logic rsp_busy;
   } slh_stat_type;

   // true when r^5 <= a, both in q30
   function automatic logic pow5_at_most(input logic [63:0] r, input logic [63:0] a);
      logic [63:0] p2;
      logic [63:0] p4;
      logic [63:0] p5;
      p2 = (r * r) >> WQ;
      if (p2 > (64'd1 << 31)) return 1'b0;
      p4 = (p2 * p2) >> WQ;
      p5 = (p4 * r) >> WQ;
      return p5 <= a;
   endfunction

   // srgb code num/den decoded to linear light; evaluated at elaboration only
   function automatic logic [LIN_W-1:0] lin_decode(input logic [63:0] num,
                                                   input tbl_kind_type kind);
      logic [63:0] den;
      logic [63:0] a;
      logic [63:0] q;
      logic [63:0] x2;
      logic [63:0] r;
      logic [63:0] c;
      logic [63:0] lin;
      unique case (kind)
         TBL_LIN8:  den = DEN_8;
         TBL_LIN16: den = DEN_16;
         default:   den = DEN_T;
      endcase
      if (num * 64'd100000 <= 64'd4045 * den) begin
         a = (num * 64'd100) << LINEAR_FRAC_BITS;
         unique case (kind)
            TBL_LIN8:  q = (a + DL_8 / 2) / DL_8;
            TBL_LIN16: q = (a + DL_16 / 2) / DL_16;
            default:   q = (a + DL_T / 2) / DL_T;
         endcase
         return q[LIN_W-1:0];
      end
      a = (num * 64'd1000 + 64'd55 * den) << WQ;
      unique case (kind)
         TBL_LIN8:  q = (a + DX_8 / 2) / DX_8;
         TBL_LIN16: q = (a + DX_16 / 2) / DX_16;
         default:   q = (a + DX_T / 2) / DX_T;
      endcase
      x2 = (q * q) >> WQ;
      // fifth root of x^2 by bisection
      r = 64'd0;
      for (int b = 30; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (pow5_at_most(c, x2)) r = c;
      end
      lin = (x2 * r) >> WQ;
      lin = (lin + (64'd1 << (WQ - 1 - LINEAR_FRAC_BITS))) >> (WQ - LINEAR_FRAC_BITS);
      return lin[LIN_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> src/slh_decode_rom.sv
// slh_decode_rom: srgb to linear decode tables (8-bit and 16-bit), registered read
// depends on slh_pkg
`default_nettype none

module slh_decode_rom (
   input  wire logic                          clock,
   input  wire logic                          mode,
   input  wire logic [slh_pkg::LIN16_AW-1:0]  idx,
   output logic      [slh_pkg::LIN_W-1:0]     q_ff
);
   import slh_pkg::*;

   logic [LIN_W-1:0] lin8_w  [LIN8_ENTRIES];
   logic [LIN_W-1:0] lin16_w [LIN16_ENTRIES];
   logic [LIN_W-1:0] q_in;

   // constant tables built at elaboration
   for (genvar i = 0; i < LIN8_ENTRIES; i++) begin : g_lin8
      localparam logic [LIN_W-1:0] V = lin_decode(64'(i), TBL_LIN8);
      assign lin8_w[i] = V;
   end
   for (genvar i = 0; i < LIN16_ENTRIES; i++) begin : g_lin16
      localparam logic [LIN_W-1:0] V = lin_decode(64'(16 * i), TBL_LIN16);
      assign lin16_w[i] = V;
   end

   // table select
   always_comb begin
      if (mode) q_in = lin16_w[idx];
      else      q_in = lin8_w[idx[7:0]];
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

endmodule

`default_nettype wire

>>> src/slh_datapath.sv
// slh_datapath: channel decode, luminance, bin search, counter memory and result register
// depends on slh_pkg and slh_decode_rom
`default_nettype none

module slh_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire slh_pkg::slh_cmd_type            cmd,
   output slh_pkg::slh_stat_type                stat,
   input  wire logic                            csr_valid,
   input  wire logic                            csr_pixel_depth_mode,
   input  wire logic                            req_operation,
   input  wire logic [15:0]                     req_red,
   input  wire logic [15:0]                     req_green,
   input  wire logic [15:0]                     req_blue,
   input  wire logic [7:0]                      req_bin_select,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [7:0]                           rsp_bin_number,
   output logic [31:0]                          rsp_bin_count
);
   import slh_pkg::*;

   logic                    mode_ff;
   logic                    op_ff;
   logic [15:0]             red_ff, green_ff, blue_ff;
   logic [BIN_W-1:0]        sel_ff;
   logic [15:0]             code;
   logic [3:0]              frac;
   logic [LIN16_AW-1:0]     idx_lo, rom_idx;
   logic [LIN_W-1:0]        rom_q;
   logic [LIN_W-1:0]        lo_ff;
   logic [LIN_W-1:0]        diff;
   logic [LIN_W+4:0]        interp;
   logic [LIN_W:0]          vsum;
   logic [LIN_W-1:0]        v_ff, v_in;
   logic [15:0]             weight;
   logic [ACC_W-1:0]        acc_ff;
   logic [LIN_W-1:0]        lum;
   logic [LIN_W-1:0]        thr_w [BIN_COUNT];
   logic [BIN_W-1:0]        bin_ff, cand;
   logic [COUNT_BITS-1:0]   hist_mem [BIN_COUNT];
   logic [BIN_COUNT-1:0]    valid_ff;
   logic [BIN_W-1:0]        addr_ff, addr_in;
   logic [COUNT_BITS-1:0]   mq_ff;
   logic                    mv_ff;
   logic [COUNT_BITS-1:0]   cur, wdata;
   logic                    rsp_valid_ff;
   logic [7:0]              rsp_num_ff;
   logic [31:0]             rsp_cnt_ff;

   // threshold table: linear value of each bin edge
   for (genvar k = 0; k < BIN_COUNT; k++) begin : g_thr
      localparam logic [LIN_W-1:0] V = (k == 0) ? '0 : lin_decode(64'(k), TBL_THRESH);
      assign thr_w[k] = V;
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid) begin
         mode_ff <= csr_pixel_depth_mode;
      end
   end

   // transaction capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_operation;
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
         sel_ff   <= req_bin_select;
      end
   end

   // channel select and table index
   always_comb begin
      case (cmd.ch)
         2'd0:    begin code = red_ff;   weight = W_RED;   end
         2'd1:    begin code = green_ff; weight = W_GREEN; end
         default: begin code = blue_ff;  weight = W_BLUE;  end
      endcase
      if (mode_ff) begin
         idx_lo = {1'b0, code[15:4]};
         frac   = code[3:0];
      end else begin
         idx_lo = {{(LIN16_AW-8){1'b0}}, code[7:0]};
         frac   = 4'd0;
      end
      rom_idx = cmd.rom_hi ? idx_lo + LIN16_AW'(1) : idx_lo;
   end

   slh_decode_rom u_rom (
      .clock (clock),
      .mode  (mode_ff),
      .idx   (rom_idx),
      .q_ff  (rom_q)
   );

   // interpolation and clamp
   always_comb begin
      diff   = (rom_q >= lo_ff) ? rom_q - lo_ff : '0;
      interp = (LIN_W+5)'(diff) * (LIN_W+5)'(frac) + (LIN_W+5)'(8);
      vsum   = {1'b0, lo_ff} + (LIN_W+1)'(interp >> 4);
      v_in   = (vsum > {1'b0, ONE_LIN}) ? ONE_LIN : vsum[LIN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_lo) lo_ff <= rom_q;
      if (cmd.cap_v)  v_ff  <= v_in;
   end

   // weighted luminance sum, rounding term preloaded
   always_ff @(posedge clock) begin
      if (cmd.load)        acc_ff <= LUM_ROUND;
      else if (cmd.acc_en) acc_ff <= acc_ff + ACC_W'(weight * v_ff);
   end
   assign lum = acc_ff[ACC_W-1:16];

   // binary search over the threshold table, one bit a step
   assign cand = bin_ff | (BIN_W'(1) << cmd.search_bit);
   always_ff @(posedge clock) begin
      if (cmd.load)                               bin_ff <= '0;
      else if (cmd.search_en && thr_w[cand] <= lum) bin_ff <= cand;
   end

   // counter memory
   assign addr_in = (op_ff == OP_READ) ? sel_ff : bin_ff;
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         addr_ff <= addr_in;
         mq_ff   <= hist_mem[addr_in];
      end
      if (cmd.update) hist_mem[addr_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         mv_ff    <= 1'b0;
      end else begin
         if (cmd.fetch)  mv_ff <= valid_ff[addr_in];
         if (cmd.update) valid_ff[addr_ff] <= 1'b1;
      end
   end

   // read-modify-write value
   always_comb begin
      cur = mv_ff ? mq_ff : '0;
      if (op_ff == OP_READ)     wdata = '0;
      else if (cur == COUNT_MAX) wdata = cur;
      else                       wdata = cur + COUNT_BITS'(1);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_num_ff <= addr_ff;
         rsp_cnt_ff <= cur;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bin_number = rsp_num_ff;
   assign rsp_bin_count  = rsp_cnt_ff;
   assign stat.op        = op_ff;
   assign stat.rsp_busy  = rsp_valid_ff && !rsp_ready;

endmodule

`default_nettype wire

>>> src/slh_ctrl.sv
// slh_ctrl: sequencer for one transaction at a time
// depends on slh_pkg
`default_nettype none

module slh_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_operation,
   output logic                       req_ready,
   input  wire slh_pkg::slh_stat_type stat,
   output slh_pkg::slh_cmd_type       cmd
);
   import slh_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] ch_ff, ch_in;
   logic [2:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff    <= 2'd0;
         step_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         step_ff  <= step_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      ch_in          = ch_ff;
      step_in        = step_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.ch         = ch_ff;
      cmd.search_bit = 3'd7 - step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               ch_in    = 2'd0;
               step_in  = 3'd0;
               state_in = (req_operation == OP_READ) ? ST_FETCH : ST_LO;
            end
         end
         ST_LO: begin
            state_in = ST_HI;
         end
         ST_HI: begin
            cmd.rom_hi = 1'b1;
            cmd.cap_lo = 1'b1;
            state_in   = ST_MIX;
         end
         ST_MIX: begin
            cmd.cap_v = 1'b1;
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            if (ch_ff == 2'd2) begin
               state_in = ST_SEARCH;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = ST_LO;
            end
         end
         ST_SEARCH: begin
            cmd.search_en = 1'b1;
            step_in       = step_ff + 3'd1;
            if (step_ff == 3'd7) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (stat.op != OP_READ) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end else if (!stat.rsp_busy) begin
               cmd.update   = 1'b1;
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

>>> src/srgb_luminance_histogram.sv
// srgb_luminance_histogram: top level, controller plus datapath
// depends on slh_pkg, slh_ctrl, slh_datapath
//
// channel  direction  contents
// req      in         operation, red, green, blue, bin_select
// rsp      out        bin_number, bin_count (read transactions only)
// csr      in         pixel_depth_mode
//
// a pixel runs through idle, then each channel in turn through the single decode
// table port (low entry, high entry, interpolate, weight), then the bin search
// and the counter read-modify-write. a bin read skips to the counter step.
// synchronous reset clears the mode and the valid bit of every counter at once.
// a read waits in its last step while the result register is still held.
`default_nettype none

module srgb_luminance_histogram (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_operation,
   input  wire logic [15:0] req_red,
   input  wire logic [15:0] req_green,
   input  wire logic [15:0] req_blue,
   input  wire logic [7:0]  req_bin_select,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_bin_number,
   output logic [31:0]      rsp_bin_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_pixel_depth_mode
);
   import slh_pkg::*;

   slh_cmd_type  cmd;
   slh_stat_type stat;

   assign csr_ready = 1'b1;

   slh_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   slh_datapath u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .csr_valid            (csr_valid),
      .csr_pixel_depth_mode (csr_pixel_depth_mode),
      .req_operation        (req_operation),
      .req_red              (req_red),
      .req_green            (req_green),
      .req_blue             (req_blue),
      .req_bin_select       (req_bin_select),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_bin_number       (rsp_bin_number),
      .rsp_bin_count        (rsp_bin_count)
   );

   // one transaction in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a transaction while busy");

   // ready comes back right after reset
   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_ready)
      else $error("not ready after reset");

   // a result is only produced from a busy sequencer
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while idle");

endmodule

`default_nettype wire
